>>> design/fcim_pkg.sv
// Shared types, constants and a helper function of the frame change interest monitor.
package fcim_pkg;

   localparam int MAX_PIXELS_DEFAULT = 65536;

   localparam int PIXEL_W     = 8;
   localparam int LEVEL_W     = 12;
   localparam int ALPHA_W     = 8;
   localparam int FRAMES_W    = 8;
   localparam int SUM_W       = 20;
   localparam int ROOT_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int DIV_STEPS   = 12;
   localparam int DIV_CNT_W   = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN  = 2'd3;

   localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 12'd256;
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET     = 8'd230;
   localparam logic [FRAMES_W-1:0] WARMUP_RESET    = 8'd8;
   localparam logic [FRAMES_W-1:0] COOLDOWN_RESET  = 8'd8;

   // Frame status codes reported with each result item.
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FIRST    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MEASURED = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SUM      = 7'b0000010,
      ST_CLASSIFY = 7'b0000100,
      ST_DIV      = 7'b0001000,
      ST_MUL      = 7'b0010000,
      ST_UPDATE   = 7'b0100000,
      ST_RESULT   = 7'b1000000
   } fcim_state_type;

   typedef struct packed {
      logic accept;
      logic sum;
      logic classify;
      logic div_step;
      logic mul;
      logic update;
      logic load;
   } fcim_cmd_type;

   typedef struct packed {
      logic                last;
      logic [STATUS_W-1:0] frame_status;
      logic                div_ovf;
      logic                div_last;
      logic                out_free;
   } fcim_status_type;

   // Floor of the square root of an 8-bit value.
   function automatic logic [ROOT_W-1:0] root_floor(input logic [PIXEL_W-1:0] d);
      logic [ROOT_W-1:0] r;
      r = '0;
      for (int k = 1; k < 16; k++) begin
         if (d >= PIXEL_W'(k * k)) begin
            r = ROOT_W'(k);
         end
      end
      return r;
   endfunction

endpackage

>>> design/frame_change_interest_monitor.sv
// Top level of the frame change interest monitor.
// Pixels enter on the req_ channel, one item each, with req_last_of_frame set on the final
// pixel of a frame; one result item per frame leaves on the rsp_ channel at that final pixel.
// The previous frame's pixel is read from the frame store in the cycle the item is accepted
// and the new pixel is written back in the next. After the final pixel of a frame, a dropped
// frame goes straight to the result; a first or length-changed frame, or a measured frame
// whose mean saturates, passes through the multiply and update steps; any other measured
// frame first has its mean computed by the bit-serial divider. The result item may wait
// behind an earlier one not yet taken. The frame store holds MAX_PIXELS bytes, starts with
// undefined contents, and needs no clearing pass: a frame is only measured after an earlier
// frame of equal length wrote every entry it reads.
// Configuration registers are written on the csr_ channel, which is always ready.
module frame_change_interest_monitor #(
   parameter int MAX_PIXELS = fcim_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcim_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcim_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fcim_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                              req_last_of_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fcim_pkg::LEVEL_W-1:0]      rsp_interest,
   output logic [fcim_pkg::LEVEL_W-1:0]      rsp_average,
   output logic                              rsp_next_preset,
   output logic [fcim_pkg::STATUS_W-1:0]     rsp_frame_status
);

   fcim_pkg::fcim_cmd_type    cmd;
   fcim_pkg::fcim_status_type status;

   assign csr_ready = 1'b1;

   fcim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcim_dpath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_pixel         (req_pixel),
      .req_last_of_frame (req_last_of_frame),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_interest      (rsp_interest),
      .rsp_average       (rsp_average),
      .rsp_next_preset   (rsp_next_preset),
      .rsp_frame_status  (rsp_frame_status)
   );

endmodule

>>> design/fcim_ram.sv
// Generic simple dual-port RAM with registered read data.
module fcim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fcim_ctrl.sv
// Sequencing state machine of the frame change interest monitor.
module fcim_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fcim_pkg::fcim_status_type status,
   output fcim_pkg::fcim_cmd_type    cmd
);

   fcim_pkg::fcim_state_type state_ff;
   fcim_pkg::fcim_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcim_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fcim_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = fcim_pkg::ST_SUM;
            end
         end
         fcim_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = status.last ? fcim_pkg::ST_CLASSIFY : fcim_pkg::ST_IDLE;
         end
         fcim_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (status.frame_status == fcim_pkg::STATUS_DROPPED) begin
               state_in = fcim_pkg::ST_RESULT;
            end else if (status.frame_status == fcim_pkg::STATUS_MEASURED &&
                         !status.div_ovf) begin
               state_in = fcim_pkg::ST_DIV;
            end else begin
               state_in = fcim_pkg::ST_MUL;
            end
         end
         fcim_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = fcim_pkg::ST_MUL;
            end
         end
         fcim_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fcim_pkg::ST_UPDATE;
         end
         fcim_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = fcim_pkg::ST_RESULT;
         end
         fcim_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = fcim_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcim_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/fcim_dpath.sv
// Datapath: frame store, energy sum, divider, smoothing and output register.
module fcim_dpath #(
   parameter int MAX_PIXELS = fcim_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [fcim_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcim_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [fcim_pkg::PIXEL_W-1:0]        req_pixel,
   input  logic                                req_last_of_frame,
   input  fcim_pkg::fcim_cmd_type              cmd,
   output fcim_pkg::fcim_status_type           status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [fcim_pkg::LEVEL_W-1:0]        rsp_interest,
   output logic [fcim_pkg::LEVEL_W-1:0]        rsp_average,
   output logic                                rsp_next_preset,
   output logic [fcim_pkg::STATUS_W-1:0]       rsp_frame_status
);

   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam int CNT_W  = $clog2(MAX_PIXELS + 2);
   localparam int CMP_W  = (CNT_W + 4 > fcim_pkg::SUM_W) ? CNT_W + 4 : fcim_pkg::SUM_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

   localparam int PIX_W = fcim_pkg::PIXEL_W;
   localparam int LVL_W = fcim_pkg::LEVEL_W;
   localparam int SUM_W = fcim_pkg::SUM_W;

   // Configuration registers.
   logic [LVL_W-1:0]                thresh_ff;
   logic [fcim_pkg::ALPHA_W-1:0]    alpha_ff;
   logic [fcim_pkg::FRAMES_W-1:0]   warmup_frames_ff;
   logic [fcim_pkg::FRAMES_W-1:0]   cooldown_frames_ff;

   // Frame state.
   logic                            store_valid_ff;
   logic [CNT_W-1:0]                stored_len_ff;
   logic [CNT_W-1:0]                pix_count_ff;
   logic [SUM_W-1:0]                energy_ff;
   logic [LVL_W-1:0]                smoothed_ff;
   logic [fcim_pkg::FRAMES_W-1:0]   warmup_cnt_ff;
   logic [fcim_pkg::FRAMES_W-1:0]   cooldown_cnt_ff;

   // Current item.
   logic [PIX_W-1:0]                px_ff;
   logic                            last_ff;
   logic                            cool_ff;

   // Frame end arithmetic.
   logic [CNT_W-1:0]                rem_ff;
   logic [fcim_pkg::DIV_STEPS-1:0]  dq_ff;
   logic [fcim_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [LVL_W-1:0]                interest_ff;
   logic [LVL_W-1:0]                avg_ff;
   logic                            trig_ff;
   logic [fcim_pkg::STATUS_W-1:0]   fstat_ff;
   logic [20:0]                     prod_new_ff;
   logic [19:0]                     prod_old_ff;

   // Output register.
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [LVL_W-1:0]                rsp_interest_ff;
   logic [LVL_W-1:0]                rsp_average_ff;
   logic                            rsp_next_preset_ff;
   logic [fcim_pkg::STATUS_W-1:0]   rsp_frame_status_ff;

   logic [PIX_W-1:0]                old_px;
   logic [PIX_W-1:0]                diff;
   logic [fcim_pkg::ROOT_W-1:0]     root;
   logic [SUM_W:0]                  sum_wide;
   logic [SUM_W-1:0]                sum_sat;
   logic                            in_range;
   logic                            do_store;
   logic                            cooling;
   logic [fcim_pkg::STATUS_W-1:0]   frame_status;
   logic                            div_ovf;
   logic [CNT_W:0]                  trial;
   logic                            trial_ge;
   logic [CNT_W:0]                  rem_next;
   logic [8:0]                      new_weight;
   logic [21:0]                     blend;
   logic [13:0]                     blend_lvl;
   logic [LVL_W-1:0]                new_level;
   logic                            warming;
   logic [LVL_W-1:0]                average;
   logic                            trigger;

   fcim_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_PIXELS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (cmd.sum && do_store),
      .wr_addr (pix_count_ff[ADDR_W-1:0]),
      .wr_data (px_ff),
      .rd_addr (pix_count_ff[ADDR_W-1:0]),
      .rd_data (old_px)
   );

   assign cooling  = cooldown_cnt_ff < cooldown_frames_ff;
   assign in_range = pix_count_ff < MAX_CNT;
   assign do_store = !cool_ff && in_range;

   assign diff     = (px_ff > old_px) ? px_ff - old_px : old_px - px_ff;
   assign root     = fcim_pkg::root_floor(diff);
   assign sum_wide = {1'b0, energy_ff} + (SUM_W + 1)'(root);
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   always_comb begin
      if (cool_ff) begin
         frame_status = fcim_pkg::STATUS_DROPPED;
      end else if (pix_count_ff > MAX_CNT || !store_valid_ff ||
                   stored_len_ff != pix_count_ff) begin
         frame_status = fcim_pkg::STATUS_FIRST;
      end else begin
         frame_status = fcim_pkg::STATUS_MEASURED;
      end
   end

   // The quotient saturates when sum * 256 / count reaches 4096.
   assign div_ovf  = CMP_W'(energy_ff) >= CMP_W'({pix_count_ff, 4'b0000});

   assign trial    = {rem_ff, dq_ff[fcim_pkg::DIV_STEPS-1]};
   assign trial_ge = trial >= {1'b0, pix_count_ff};
   assign rem_next = trial_ge ? trial - {1'b0, pix_count_ff} : trial;

   assign new_weight = 9'd256 - {1'b0, alpha_ff};
   assign blend      = 22'(prod_new_ff) + 22'(prod_old_ff) + 22'd128;
   assign blend_lvl  = blend[21:8];
   assign new_level  = (blend_lvl > 14'(4095)) ? '1 : blend_lvl[LVL_W-1:0];
   assign warming    = warmup_cnt_ff < warmup_frames_ff;
   assign average    = warming ? thresh_ff : new_level;
   assign trigger    = average < thresh_ff;

   assign status.last         = last_ff;
   assign status.frame_status = frame_status;
   assign status.div_ovf      = div_ovf;
   assign status.div_last     = div_cnt_ff == fcim_pkg::DIV_CNT_W'(fcim_pkg::DIV_STEPS - 1);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid_in = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff          <= fcim_pkg::THRESHOLD_RESET;
         alpha_ff           <= fcim_pkg::ALPHA_RESET;
         warmup_frames_ff   <= fcim_pkg::WARMUP_RESET;
         cooldown_frames_ff <= fcim_pkg::COOLDOWN_RESET;
         store_valid_ff     <= 1'b0;
         stored_len_ff      <= '0;
         pix_count_ff       <= '0;
         energy_ff          <= '0;
         smoothed_ff        <= '0;
         warmup_cnt_ff      <= '0;
         cooldown_cnt_ff    <= '0;
         div_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               fcim_pkg::CSR_THRESHOLD: thresh_ff          <= csr_data;
               fcim_pkg::CSR_ALPHA:     alpha_ff           <= csr_data[fcim_pkg::ALPHA_W-1:0];
               fcim_pkg::CSR_WARMUP:    warmup_frames_ff   <= csr_data[fcim_pkg::FRAMES_W-1:0];
               fcim_pkg::CSR_COOLDOWN:  cooldown_frames_ff <= csr_data[fcim_pkg::FRAMES_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.sum) begin
            if (do_store) begin
               energy_ff <= sum_sat;
            end
            if (pix_count_ff <= MAX_CNT) begin
               pix_count_ff <= pix_count_ff + 1'b1;
            end
         end
         if (cmd.classify) begin
            div_cnt_ff <= '0;
            if (frame_status == fcim_pkg::STATUS_DROPPED) begin
               cooldown_cnt_ff <= cooldown_cnt_ff + 1'b1;
            end else if (frame_status == fcim_pkg::STATUS_FIRST) begin
               if (pix_count_ff > MAX_CNT) begin
                  store_valid_ff <= 1'b0;
                  stored_len_ff  <= '0;
               end else begin
                  store_valid_ff <= 1'b1;
                  stored_len_ff  <= pix_count_ff;
               end
            end
         end
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (cmd.update) begin
            if (trigger) begin
               smoothed_ff     <= thresh_ff;
               warmup_cnt_ff   <= '0;
               cooldown_cnt_ff <= '0;
            end else if (warming) begin
               warmup_cnt_ff <= warmup_cnt_ff + 1'b1;
            end else begin
               smoothed_ff <= new_level;
            end
         end
         if (cmd.load) begin
            pix_count_ff <= '0;
            energy_ff    <= '0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff   <= req_pixel;
         last_ff <= req_last_of_frame;
         cool_ff <= cooling;
      end
      if (cmd.classify) begin
         fstat_ff <= frame_status;
         avg_ff   <= '0;
         trig_ff  <= 1'b0;
         rem_ff   <= CNT_W'(energy_ff[SUM_W-1:4]);
         dq_ff    <= {energy_ff[3:0], 8'd0};
         if (frame_status == fcim_pkg::STATUS_MEASURED && div_ovf) begin
            interest_ff <= '1;
         end else begin
            interest_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_next[CNT_W-1:0];
         dq_ff  <= {dq_ff[fcim_pkg::DIV_STEPS-2:0], trial_ge};
         if (status.div_last) begin
            interest_ff <= {dq_ff[fcim_pkg::DIV_STEPS-2:0], trial_ge};
         end
      end
      if (cmd.mul) begin
         prod_new_ff <= interest_ff * new_weight;
         prod_old_ff <= smoothed_ff * alpha_ff;
      end
      if (cmd.update) begin
         avg_ff  <= average;
         trig_ff <= trigger;
      end
      if (cmd.load) begin
         rsp_interest_ff     <= interest_ff;
         rsp_average_ff      <= avg_ff;
         rsp_next_preset_ff  <= trig_ff;
         rsp_frame_status_ff <= fstat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interest     = rsp_interest_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_next_preset  = rsp_next_preset_ff;
   assign rsp_frame_status = rsp_frame_status_ff;

endmodule

>>> design/fcim_checker.sv
// Port-level checks of the frame change interest monitor and their bind.
module fcim_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fcim_pkg::LEVEL_W-1:0]      rsp_interest,
   input logic [fcim_pkg::LEVEL_W-1:0]      rsp_average,
   input logic                              rsp_next_preset,
   input logic [fcim_pkg::STATUS_W-1:0]     rsp_frame_status
);

   // A result item that waits keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interest) &&
      $stable(rsp_average) && $stable(rsp_next_preset) && $stable(rsp_frame_status))
      else $error("result item changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_status == fcim_pkg::STATUS_DROPPED ||
                    rsp_frame_status == fcim_pkg::STATUS_FIRST ||
                    rsp_frame_status == fcim_pkg::STATUS_MEASURED)
      else $error("unknown frame status");

   // A frame dropped during cooldown reports zero interest, zero average and no preset.
   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == fcim_pkg::STATUS_DROPPED |->
      rsp_interest == '0 && rsp_average == '0 && !rsp_next_preset)
      else $error("dropped frame carries data");

   // Without a matching earlier frame there is nothing to compare against.
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == fcim_pkg::STATUS_FIRST |-> rsp_interest == '0)
      else $error("first frame reports nonzero interest");

endmodule

bind frame_change_interest_monitor fcim_checker u_fcim_checker (.*);

>>> bench/frame_change_interest_monitor_tb.sv
// Self-checking bench for the frame change interest monitor with a per-frame result predictor.
`timescale 1ns / 100ps

// Frame store size used for the bench; small so that overlong frames stay cheap.
localparam int FRAME_CAP = 32;

typedef struct packed {
   logic [fcim_pkg::LEVEL_W-1:0]  interest;
   logic [fcim_pkg::LEVEL_W-1:0]  average;
   logic                          next_preset;
   logic [fcim_pkg::STATUS_W-1:0] frame_status;
} frame_report_type;

class frame_interest_tracker;
   localparam int unsigned ENERGY_LIMIT = (1 << fcim_pkg::SUM_W) - 1;
   localparam int unsigned LEVEL_LIMIT  = (1 << fcim_pkg::LEVEL_W) - 1;

   int unsigned threshold;
   int unsigned alpha;
   int unsigned warmup_len;
   int unsigned cooldown_len;

   bit [7:0]    last_frame [FRAME_CAP];
   bit          have_frame;
   int unsigned frame_len;
   int unsigned pixels_seen;
   int unsigned energy;
   int unsigned level;
   int unsigned warm_seen;
   int unsigned cool_seen;

   frame_report_type awaited_reports[$];
   int unsigned      mismatches;

   function new();
      threshold    = 32'(fcim_pkg::THRESHOLD_RESET);
      alpha        = 32'(fcim_pkg::ALPHA_RESET);
      warmup_len   = 32'(fcim_pkg::WARMUP_RESET);
      cooldown_len = 32'(fcim_pkg::COOLDOWN_RESET);
      foreach (last_frame[k]) last_frame[k] = '0;
      have_frame  = 1'b0;
      frame_len   = 0;
      pixels_seen = 0;
      energy      = 0;
      level       = 0;
      warm_seen   = 0;
      cool_seen   = 0;
      mismatches  = 0;
   endfunction

   function void set_register(logic [fcim_pkg::CSR_INDEX_W-1:0] index,
                              logic [fcim_pkg::CSR_DATA_W-1:0] data);
      case (index)
         fcim_pkg::CSR_THRESHOLD: threshold    = 32'(data);
         fcim_pkg::CSR_ALPHA:     alpha        = 32'(data[7:0]);
         fcim_pkg::CSR_WARMUP:    warmup_len   = 32'(data[7:0]);
         fcim_pkg::CSR_COOLDOWN:  cooldown_len = 32'(data[7:0]);
         default: ;
      endcase
   endfunction

   static function int unsigned floor_root(int unsigned d);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= d) r++;
      return r;
   endfunction

   function void take_pixel(logic [7:0] px, logic last);
      bit               cooling;
      int unsigned      old_px;
      int unsigned      new_px;
      int unsigned      diff;
      int unsigned      n;
      int unsigned      total;
      int unsigned      mean;
      int unsigned      avg;
      frame_report_type rep;
      cooling = cool_seen < cooldown_len;
      new_px  = 32'(px);
      if (!cooling && pixels_seen < FRAME_CAP) begin
         old_px = 32'(last_frame[pixels_seen]);
         diff   = (new_px > old_px) ? new_px - old_px : old_px - new_px;
         energy = energy + floor_root(diff);
         if (energy > ENERGY_LIMIT) energy = ENERGY_LIMIT;
         last_frame[pixels_seen] = px;
      end
      if (pixels_seen <= FRAME_CAP) pixels_seen++;
      if (!last) return;

      n           = pixels_seen;
      total       = energy;
      pixels_seen = 0;
      energy      = 0;
      rep         = '0;
      mean        = 0;

      // A frame that ends while cooling down is dropped whole.
      if (cooling) begin
         cool_seen++;
         rep.frame_status = fcim_pkg::STATUS_DROPPED;
         awaited_reports.push_back(rep);
         return;
      end

      if (n > FRAME_CAP) begin
         have_frame       = 1'b0;
         frame_len        = 0;
         rep.frame_status = fcim_pkg::STATUS_FIRST;
      end else if (!have_frame || frame_len != n) begin
         have_frame       = 1'b1;
         frame_len        = n;
         rep.frame_status = fcim_pkg::STATUS_FIRST;
      end else begin
         mean = (total * 256) / n;
         if (mean > LEVEL_LIMIT) mean = LEVEL_LIMIT;
         rep.frame_status = fcim_pkg::STATUS_MEASURED;
      end

      if (warm_seen < warmup_len) begin
         warm_seen++;
         avg = threshold;
      end else begin
         level = (mean * (256 - alpha) + level * alpha + 128) >> 8;
         if (level > LEVEL_LIMIT) level = LEVEL_LIMIT;
         avg = level;
      end

      if (avg < threshold) begin
         rep.next_preset = 1'b1;
         level           = threshold;
         warm_seen       = 0;
         cool_seen       = 0;
      end

      rep.interest = fcim_pkg::LEVEL_W'(mean);
      rep.average  = fcim_pkg::LEVEL_W'(avg);
      awaited_reports.push_back(rep);
   endfunction

   function void check_report(frame_report_type got);
      frame_report_type want;
      if (awaited_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: interest %0d average %0d next_preset %0d frame_status %0d",
                     got.interest, got.average, got.next_preset, got.frame_status);
         return;
      end
      want = awaited_reports.pop_front();
      if (got.interest !== want.interest || got.average !== want.average ||
          got.next_preset !== want.next_preset || got.frame_status !== want.frame_status) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch (expected/actual): interest %0d/%0d average %0d/%0d ",
                      "next_preset %0d/%0d frame_status %0d/%0d"},
                     want.interest, got.interest, want.average, got.average,
                     want.next_preset, got.next_preset, want.frame_status, got.frame_status);
      end
   endfunction

   function int unsigned pending();
      return awaited_reports.size();
   endfunction
endclass

module frame_change_interest_monitor_tb;
   localparam int unsigned QUIET_CYCLES = 24;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned RANDOM_ITEMS = 1450;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [fcim_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [fcim_pkg::CSR_DATA_W-1:0]   csr_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [fcim_pkg::PIXEL_W-1:0]      req_pixel = '0;
   logic                              req_last_of_frame = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [fcim_pkg::LEVEL_W-1:0]      rsp_interest;
   logic [fcim_pkg::LEVEL_W-1:0]      rsp_average;
   logic                              rsp_next_preset;
   logic [fcim_pkg::STATUS_W-1:0]     rsp_frame_status;

   frame_interest_tracker tracker = new();

   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned hold_asks  = 0;

   frame_change_interest_monitor #(
      .MAX_PIXELS(FRAME_CAP)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_last_of_frame(req_last_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_interest     (rsp_interest),
      .rsp_average      (rsp_average),
      .rsp_next_preset  (rsp_next_preset),
      .rsp_frame_status (rsp_frame_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("status: fail");
      $finish;
   end

   // Offers one pixel and holds it until taken; bursts may end in a random gap.
   task automatic send_pixel(input logic [7:0] px, input logic last);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_pixel         <= px;
      req_last_of_frame <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_pixel(px, last);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_register(input logic [fcim_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [fcim_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering pixels and waits until the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int unsigned      run_left;
      int unsigned      hold_left;
      int unsigned      holds_seen;
      bit               ready_phase;
      frame_report_type got;
      run_left    = 0;
      hold_left   = 0;
      holds_seen  = 0;
      ready_phase = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            got.interest     = rsp_interest;
            got.average      = rsp_average;
            got.next_preset  = rsp_next_preset;
            got.frame_status = rsp_frame_status;
            tracker.check_report(got);
         end
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               ready_phase = !ready_phase;
               if (ready_phase) begin
                  run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                        : $urandom_range(1, 12);
               end else begin
                  run_left = $urandom_range(1, 6);
               end
            end
            run_left--;
            rsp_ready <= ready_phase;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  scene [FRAME_CAP];
      logic [7:0]  px;
      int unsigned stop_at;
      int unsigned next_hold_at;
      int unsigned base_len;
      int unsigned len;
      int unsigned frames;
      int unsigned jitter;
      int unsigned pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Upper data bits are set on the 8-bit registers; they must be ignored.
      write_register(fcim_pkg::CSR_THRESHOLD, 12'h000);
      write_register(fcim_pkg::CSR_ALPHA,     12'hF00);
      write_register(fcim_pkg::CSR_WARMUP,    12'hA01);
      write_register(fcim_pkg::CSR_COOLDOWN,  12'h501);

      // Dropped during cooldown, then first frame, measured at full swing,
      // and a length change.
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0,   1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0,   1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0,   1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd7,   1'b1);
      settle();

      // A still frame under the highest threshold triggers the next preset.
      write_register(fcim_pkg::CSR_THRESHOLD, 12'hFFF);
      write_register(fcim_pkg::CSR_ALPHA,     12'h0FF);
      send_pixel(8'd7,   1'b1);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd127, 1'b1);

      // Cooldown is lengthened in the middle of a frame, so that frame is dropped.
      send_pixel(8'd1,   1'b0);
      settle();
      write_register(fcim_pkg::CSR_COOLDOWN, 12'hC02);
      write_register(fcim_pkg::CSR_WARMUP,   12'h300);
      send_pixel(8'd254, 1'b1);

      stop_at      = items_sent + RANDOM_ITEMS;
      next_hold_at = items_sent + 300;
      while (items_sent < stop_at) begin
         settle();
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0:       pick = 0;
               1:       pick = 4095;
               2, 3:    pick = $urandom_range(0, 600);
               4:       pick = $urandom_range(0, 4095);
               default: pick = $urandom_range(100, 2000);
            endcase
            write_register(fcim_pkg::CSR_THRESHOLD, 12'(pick));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0:       pick = 0;
               1:       pick = 255;
               default: pick = $urandom_range(0, 255);
            endcase
            write_register(fcim_pkg::CSR_ALPHA, {4'($urandom_range(0, 15)), 8'(pick)});
         end
         if ($urandom_range(0, 1)) begin
            pick = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 3);
            write_register(fcim_pkg::CSR_WARMUP, {4'($urandom_range(0, 15)), 8'(pick)});
         end
         if ($urandom_range(0, 1)) begin
            pick = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 2);
            write_register(fcim_pkg::CSR_COOLDOWN, {4'($urandom_range(0, 15)), 8'(pick)});
         end

         // A long receiver stall while pixels keep coming backs the block up.
         if (items_sent >= next_hold_at) begin
            hold_asks    <= hold_asks + 1;
            next_hold_at  = next_hold_at + 600;
         end

         case ($urandom_range(0, 7))
            0:       base_len = 1;
            1, 2, 3: base_len = $urandom_range(2, 8);
            4, 5:    base_len = $urandom_range(9, 16);
            6:       base_len = $urandom_range(17, FRAME_CAP);
            default: base_len = FRAME_CAP;
         endcase
         case ($urandom_range(0, 4))
            0:       jitter = 0;
            1:       jitter = 1;
            2:       jitter = 3;
            3:       jitter = 15;
            default: jitter = 255;
         endcase
         foreach (scene[k]) scene[k] = 8'($urandom_range(0, 255));

         // Mostly frames of one length so they get measured; now and then a
         // different length or an overlong frame breaks the sequence.
         frames = $urandom_range(3, 10);
         repeat (frames) begin
            pick = $urandom_range(0, 31);
            if (pick == 0) len = $urandom_range(1, FRAME_CAP);
            else if (pick == 1) len = $urandom_range(FRAME_CAP + 1, FRAME_CAP + 4);
            else len = base_len;
            for (int k = 0; k < len; k++) begin
               if (k < FRAME_CAP) px = scene[k] + 8'($urandom_range(0, jitter));
               else px = 8'($urandom_range(0, 255));
               send_pixel(px, k == len - 1);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
